@@ sv/rrp_pkg.sv @@
`timescale 1ns / 1ps

package rrp_pkg;

  localparam int MAX_FRAME_BYTES = 128;

  localparam logic [7:0] ST_OK_CODE   = 8'h81;
  localparam logic [7:0] ST_FAIL_CODE = 8'h80;
  localparam logic [7:0] XOR_START    = 8'd2;
  localparam logic [7:0] STATUS_POS   = 8'd3;
  localparam logic [7:0] LENGTH_POS   = 8'd4;
  localparam logic [7:0] ID_START     = 8'd5;
  localparam logic [7:0] MIN_FRAME    = 8'd4;

  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_IDLE = 1'b1
  } rrp_in_kind_t;

  typedef enum logic {
    OUT_ID     = 1'b0,
    OUT_STATUS = 1'b1
  } rrp_out_kind_t;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FAIL   = 2'd1,
    STATUS_BAD    = 2'd2,
    STATUS_CKSUM  = 2'd3
  } rrp_status_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } rrp_item_t;

  typedef struct packed {
    logic       out_kind;
    logic [7:0] id_byte;
    logic [7:0] id_index;
    logic [7:0] id_length;
    logic [1:0] status;
    logic       last;
  } rrp_result_t;

endpackage

@@ sv/rrp_if.sv @@
`timescale 1ns / 1ps

interface rrp_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface rrp_out_if;
  logic       valid;
  logic       ready;
  logic       out_kind;
  logic [7:0] id_byte;
  logic [7:0] id_index;
  logic [7:0] id_length;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output out_kind, output id_byte, output id_index,
                  output id_length, output status, output last, input ready);
  modport sink   (input valid, input out_kind, input id_byte, input id_index,
                  input id_length, input status, input last, output ready);
endinterface

interface rrp_cfg_if;
  logic valid;
  logic ready;
  logic expect_id;

  modport source (output valid, output expect_id, input ready);
  modport sink   (input valid, input expect_id, output ready);
endinterface

@@ sv/rrp_in_stage.sv @@
`timescale 1ns / 1ps

module rrp_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rrp_pkg::rrp_item_t in_item,
  input  logic              advance,
  output logic              item_valid,
  output rrp_pkg::rrp_item_t item
);

  logic               valid_r;
  rrp_pkg::rrp_item_t item_r;

  // The register empties whenever the next stage moves, so it refills in the same cycle.
  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

@@ sv/rrp_frame_parser.sv @@
`timescale 1ns / 1ps

module rrp_frame_parser #(
  parameter int MAX_FRAME_BYTES = rrp_pkg::MAX_FRAME_BYTES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic                 cfg_expect_id,
  input  logic                 take,
  input  rrp_pkg::rrp_item_t   item,
  output logic                 res_valid,
  output rrp_pkg::rrp_result_t res
);

  localparam logic [7:0] MaxBytes = 8'(MAX_FRAME_BYTES);

  logic       expect_id_r;
  logic [7:0] byte_count_r, byte_count_nxt;
  logic [7:0] xor_acc_r, xor_acc_nxt;
  logic [7:0] status_byte_r, status_byte_nxt;
  logic [7:0] length_byte_r, length_byte_nxt;
  logic       cks_seen_r, cks_seen_nxt;
  logic [8:0] cks_pos;
  logic [7:0] idx;

  assign idx     = byte_count_r;
  assign cks_pos = {1'b0, rrp_pkg::ID_START} + {1'b0, length_byte_r};

  always_comb begin
    byte_count_nxt  = byte_count_r;
    xor_acc_nxt     = xor_acc_r;
    status_byte_nxt = status_byte_r;
    length_byte_nxt = length_byte_r;
    cks_seen_nxt    = cks_seen_r;
    res_valid       = 1'b0;
    res             = '0;
    if (take) begin
      if (item.kind == rrp_pkg::KIND_BYTE) begin
        // Bytes beyond the buffer limit are dropped and not counted.
        if (idx < MaxBytes) begin
          byte_count_nxt = idx + 8'd1;
          if (idx >= rrp_pkg::XOR_START && !cks_seen_r) begin
            xor_acc_nxt = xor_acc_r ^ item.rx_byte;
          end
          if (idx == rrp_pkg::STATUS_POS) begin
            status_byte_nxt = item.rx_byte;
          end
          if (idx == rrp_pkg::LENGTH_POS) begin
            length_byte_nxt = item.rx_byte;
          end
          if (idx >= rrp_pkg::ID_START && !cks_seen_r) begin
            if ({1'b0, idx} < cks_pos) begin
              if (expect_id_r && status_byte_r == rrp_pkg::ST_OK_CODE) begin
                res_valid     = 1'b1;
                res.out_kind  = rrp_pkg::OUT_ID;
                res.id_byte   = item.rx_byte;
                res.id_index  = idx - rrp_pkg::ID_START;
                res.id_length = length_byte_r;
                res.status    = rrp_pkg::STATUS_OK;
                res.last      = 1'b0;
              end
            end else if ({1'b0, idx} == cks_pos) begin
              cks_seen_nxt = 1'b1;
            end
          end
        end
      end else begin
        res_valid     = 1'b1;
        res.out_kind  = rrp_pkg::OUT_STATUS;
        res.last      = 1'b1;
        res.id_length = (byte_count_r > rrp_pkg::LENGTH_POS) ? length_byte_r : 8'd0;
        priority if (byte_count_r < rrp_pkg::MIN_FRAME) begin
          res.status = rrp_pkg::STATUS_BAD;
        end else if (status_byte_r == rrp_pkg::ST_FAIL_CODE) begin
          res.status = rrp_pkg::STATUS_FAIL;
        end else if (status_byte_r != rrp_pkg::ST_OK_CODE) begin
          res.status = rrp_pkg::STATUS_BAD;
        end else if (!expect_id_r) begin
          res.status = rrp_pkg::STATUS_OK;
        end else if (byte_count_r <= rrp_pkg::LENGTH_POS || !cks_seen_r) begin
          res.status = rrp_pkg::STATUS_BAD;
        end else if (xor_acc_r != 8'd0) begin
          res.status = rrp_pkg::STATUS_CKSUM;
        end else begin
          res.status = rrp_pkg::STATUS_OK;
        end
        byte_count_nxt  = '0;
        xor_acc_nxt     = '0;
        status_byte_nxt = '0;
        length_byte_nxt = '0;
        cks_seen_nxt    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_id_r   <= 1'b1;
      byte_count_r  <= '0;
      xor_acc_r     <= '0;
      status_byte_r <= '0;
      length_byte_r <= '0;
      cks_seen_r    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        expect_id_r <= cfg_expect_id;
      end
      byte_count_r  <= byte_count_nxt;
      xor_acc_r     <= xor_acc_nxt;
      status_byte_r <= status_byte_nxt;
      length_byte_r <= length_byte_nxt;
      cks_seen_r    <= cks_seen_nxt;
    end
  end

  a_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (take && item.kind == rrp_pkg::KIND_IDLE) |=> (byte_count_r == 8'd0 && !cks_seen_r))
    else $error("frame state not cleared after end of frame");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= MaxBytes)
    else $error("byte count passed the buffer limit");

  a_cks_after_id: assert property (@(posedge clk) disable iff (!rst_n)
    cks_seen_r |-> byte_count_r > rrp_pkg::ID_START)
    else $error("checksum flagged before the ID field");

  a_id_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.out_kind == rrp_pkg::OUT_ID) |-> res.id_index < res.id_length)
    else $error("ID byte index outside the declared length");

endmodule

@@ sv/rrp_out_stage.sv @@
`timescale 1ns / 1ps

module rrp_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_valid,
  input  rrp_pkg::rrp_result_t res,
  output logic                 advance,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rrp_pkg::rrp_result_t out_res
);

  logic                 valid_r;
  rrp_pkg::rrp_result_t res_r;

  assign advance   = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res_r <= res;
    end
  end

endmodule

@@ sv/rfid_reader_response_parser.sv @@
`timescale 1ns / 1ps

// Reply-frame parser for a serial RFID reader.
// in_ch carries one event per transfer: a received byte (kind 0) or a line-idle
// marker (kind 1) that closes the frame. out_ch carries ID bytes as they arrive
// (when ID parsing is on and the status byte reads ok) and one status result with
// last set for every idle marker. cfg_ch writes the expect_id register; it is
// always ready and should only be written while no event is in the pipeline.
// An event is registered in the input register, goes through the frame-state
// update and is registered in the output register before out_ch.valid rises; a
// stall can hold it on the way. Throughput is one event per cycle while
// out_ch.ready stays high, set by the single frame-state update between those registers.
// Events that produce no result still pass through the pipeline and take one slot.
// Reset (rst_n low, synchronous) empties both registers, clears the frame state and
// sets expect_id to 1. When the receiver holds out_ch.ready low, the output
// register holds its result, the pipeline stops, and in_ch.ready drops once the
// input register is also full.
module rfid_reader_response_parser #(
  parameter int MAX_FRAME_BYTES = rrp_pkg::MAX_FRAME_BYTES
) (
  input logic       clk,
  input logic       rst_n,
  rrp_in_if.sink    in_ch,
  rrp_out_if.source out_ch,
  rrp_cfg_if.sink   cfg_ch
);

  rrp_pkg::rrp_item_t   in_item;
  rrp_pkg::rrp_item_t   item;
  rrp_pkg::rrp_result_t res;
  rrp_pkg::rrp_result_t out_res;
  logic                 item_valid;
  logic                 advance;
  logic                 res_valid;

  assign in_item.kind    = in_ch.kind;
  assign in_item.rx_byte = in_ch.rx_byte;
  assign cfg_ch.ready    = 1'b1;

  rrp_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  rrp_frame_parser #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_ch.valid),
    .cfg_expect_id (cfg_ch.expect_id),
    .take          (item_valid && advance),
    .item          (item),
    .res_valid     (res_valid),
    .res           (res)
  );

  rrp_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.out_kind  = out_res.out_kind;
  assign out_ch.id_byte   = out_res.id_byte;
  assign out_ch.id_index  = out_res.id_index;
  assign out_ch.id_length = out_res.id_length;
  assign out_ch.status    = out_res.status;
  assign out_ch.last      = out_res.last;

endmodule

@@ verif/rrp_frame_checker.sv @@
`timescale 1ns / 1ps

module rrp_frame_checker (
  input  logic clk,
  input  logic rst_n,
  rrp_in_if    in_mon,
  rrp_out_if   out_mon,
  rrp_cfg_if   cfg_mon,
  output int   fail_count,
  output int   pending
);

  logic                 id_enabled;
  int                   bytes_kept;
  logic [7:0]           xor_sum;
  logic [7:0]           status_seen;
  logic [7:0]           length_seen;
  logic                 sum_seen;
  rrp_pkg::rrp_result_t frame_results_q[$];

  function automatic void clear_frame();
    bytes_kept  = 0;
    xor_sum     = '0;
    status_seen = '0;
    length_seen = '0;
    sum_seen    = 1'b0;
  endfunction

  // Advances the frame state by one event and returns 1 when the event yields a result.
  function automatic bit parse_event(input logic kind, input logic [7:0] b,
                                     output rrp_pkg::rrp_result_t res);
    int pos;
    int sum_pos;
    res = '0;
    if (kind == rrp_pkg::KIND_BYTE) begin
      pos = bytes_kept;
      if (pos >= rrp_pkg::MAX_FRAME_BYTES) return 1'b0;
      bytes_kept = pos + 1;
      sum_pos = int'(rrp_pkg::ID_START) + int'(length_seen);
      if (pos >= int'(rrp_pkg::XOR_START) && !sum_seen) xor_sum = xor_sum ^ b;
      if (pos == int'(rrp_pkg::STATUS_POS)) status_seen = b;
      if (pos == int'(rrp_pkg::LENGTH_POS)) length_seen = b;
      if (pos >= int'(rrp_pkg::ID_START) && !sum_seen) begin
        if (pos < sum_pos) begin
          if (id_enabled && status_seen == rrp_pkg::ST_OK_CODE) begin
            res.out_kind  = rrp_pkg::OUT_ID;
            res.id_byte   = b;
            res.id_index  = 8'(pos - int'(rrp_pkg::ID_START));
            res.id_length = length_seen;
            res.status    = rrp_pkg::STATUS_OK;
            res.last      = 1'b0;
            return 1'b1;
          end
        end else if (pos == sum_pos) begin
          sum_seen = 1'b1;
        end
      end
      return 1'b0;
    end
    res.out_kind  = rrp_pkg::OUT_STATUS;
    res.id_length = (bytes_kept > int'(rrp_pkg::LENGTH_POS)) ? length_seen : 8'd0;
    res.last      = 1'b1;
    if (bytes_kept < int'(rrp_pkg::MIN_FRAME)) res.status = rrp_pkg::STATUS_BAD;
    else if (status_seen == rrp_pkg::ST_FAIL_CODE) res.status = rrp_pkg::STATUS_FAIL;
    else if (status_seen != rrp_pkg::ST_OK_CODE) res.status = rrp_pkg::STATUS_BAD;
    else if (!id_enabled) res.status = rrp_pkg::STATUS_OK;
    else if (bytes_kept <= int'(rrp_pkg::LENGTH_POS) || !sum_seen)
      res.status = rrp_pkg::STATUS_BAD;
    else if (xor_sum != 8'd0) res.status = rrp_pkg::STATUS_CKSUM;
    else res.status = rrp_pkg::STATUS_OK;
    clear_frame();
    return 1'b1;
  endfunction

  task automatic report_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    rrp_pkg::rrp_result_t want;
    rrp_pkg::rrp_result_t got;
    if (!rst_n) begin
      id_enabled = 1'b1;
      fail_count = 0;
      clear_frame();
      frame_results_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.out_kind  = out_mon.out_kind;
        got.id_byte   = out_mon.id_byte;
        got.id_index  = out_mon.id_index;
        got.id_length = out_mon.id_length;
        got.status    = out_mon.status;
        got.last      = out_mon.last;
        if (frame_results_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %p", $time, got);
          fail_count++;
        end else begin
          want = frame_results_q.pop_front();
          report_field("out_kind", want.out_kind, got.out_kind);
          report_field("id_byte", want.id_byte, got.id_byte);
          report_field("id_index", want.id_index, got.id_index);
          report_field("id_length", want.id_length, got.id_length);
          report_field("status", want.status, got.status);
          report_field("last", want.last, got.last);
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) id_enabled = cfg_mon.expect_id;
      if (in_mon.valid && in_mon.ready) begin
        if (parse_event(in_mon.kind, in_mon.rx_byte, want)) frame_results_q.push_back(want);
      end
    end
    pending <= frame_results_q.size();
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 100;

  logic       clk;
  logic       rst_n;
  bit         gaps_on = 1'b1;
  int         cycles = 0;
  int         fail_count;
  int         pending;
  int         items_sent = 0;
  int         frame_pos = 0;
  logic [7:0] frame_q[$];

  rrp_in_if  in_ch ();
  rrp_out_if out_ch ();
  rrp_cfg_if cfg_ch ();

  rfid_reader_response_parser u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  rrp_frame_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= !gaps_on || ($urandom_range(0, 99) >= 36);
    end
  end

  task automatic send_event(input logic kind, input logic [7:0] b);
    while (gaps_on && $urandom_range(0, 99) < 36) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= kind;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // Bytes past the frame limit are dropped by the block and are not counted.
    if (kind == rrp_pkg::KIND_IDLE) begin
      items_sent++;
      frame_pos = 0;
    end else begin
      if (frame_pos < rrp_pkg::MAX_FRAME_BYTES) items_sent++;
      frame_pos++;
    end
  endtask

  // The pipeline can still hold events that yield nothing, so more waiting follows once pending is zero.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_expect_id(input logic value);
    drain_results();
    cfg_ch.valid     <= 1'b1;
    cfg_ch.expect_id <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic void build_frame(input logic [7:0] stat, input logic [7:0] len,
                                      input bit bad_sum);
    logic [7:0] sum;
    logic [7:0] b;
    frame_q.delete();
    frame_q.push_back(8'($urandom));
    frame_q.push_back(8'($urandom));
    sum = 8'($urandom);
    frame_q.push_back(sum);
    frame_q.push_back(stat);
    frame_q.push_back(len);
    sum = sum ^ stat ^ len;
    for (int i = 0; i < int'(len); i++) begin
      b = 8'($urandom);
      frame_q.push_back(b);
      sum = sum ^ b;
    end
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    frame_q.push_back(sum);
  endfunction

  // Sends the first keep bytes of the frame (all of them when keep is negative),
  // then extra trailing bytes, then the idle event.
  task automatic send_frame(input int keep, input int extra);
    int n;
    n = (keep < 0 || keep > frame_q.size()) ? frame_q.size() : keep;
    for (int i = 0; i < n; i++) send_event(rrp_pkg::KIND_BYTE, frame_q[i]);
    repeat (extra) send_event(rrp_pkg::KIND_BYTE, 8'($urandom));
    send_event(rrp_pkg::KIND_IDLE, 8'($urandom));
  endtask

  initial begin
    int start_items;
    int last_cfg;
    int r;
    int n;
    logic [7:0] stat;
    logic [7:0] len;

    in_ch.valid      <= 1'b0;
    in_ch.kind       <= rrp_pkg::KIND_BYTE;
    in_ch.rx_byte    <= 8'd0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.expect_id <= 1'b1;
    rst_n            <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_expect_id(1'b1);
    send_event(rrp_pkg::KIND_IDLE, 8'hFF);
    build_frame(rrp_pkg::ST_OK_CODE, 8'd2, 1'b0);
    send_frame(3, 0);
    send_frame(4, 0);
    send_frame(6, 0);
    build_frame(rrp_pkg::ST_FAIL_CODE, 8'd3, 1'b0);
    send_frame(-1, 0);
    build_frame(8'h7F, 8'd3, 1'b0);
    send_frame(-1, 0);
    build_frame(rrp_pkg::ST_OK_CODE, 8'd0, 1'b0);
    send_frame(-1, 0);
    build_frame(rrp_pkg::ST_OK_CODE, 8'd4, 1'b1);
    send_frame(-1, 0);
    build_frame(rrp_pkg::ST_OK_CODE, 8'd4, 1'b0);
    send_frame(-1, 3);
    // Checksum lands on the last kept byte, then the frame overruns the buffer.
    build_frame(rrp_pkg::ST_OK_CODE, 8'd122, 1'b0);
    send_frame(-1, 4);
    build_frame(rrp_pkg::ST_OK_CODE, 8'd123, 1'b0);
    send_frame(-1, 0);
    build_frame(rrp_pkg::ST_OK_CODE, 8'd255, 1'b0);
    send_frame(-1, 0);

    write_expect_id(1'b0);
    build_frame(rrp_pkg::ST_OK_CODE, 8'd3, 1'b0);
    send_frame(-1, 0);
    build_frame(rrp_pkg::ST_OK_CODE, 8'd3, 1'b1);
    send_frame(-1, 0);
    send_frame(4, 0);
    build_frame(rrp_pkg::ST_FAIL_CODE, 8'd1, 1'b0);
    send_frame(-1, 0);

    // Register changes while a frame is half received.
    build_frame(rrp_pkg::ST_OK_CODE, 8'd5, 1'b0);
    for (int i = 0; i < 5; i++) send_event(rrp_pkg::KIND_BYTE, frame_q[i]);
    write_expect_id(1'b1);
    for (int i = 5; i < frame_q.size(); i++) send_event(rrp_pkg::KIND_BYTE, frame_q[i]);
    send_event(rrp_pkg::KIND_IDLE, 8'h00);
    build_frame(rrp_pkg::ST_OK_CODE, 8'd6, 1'b0);
    for (int i = 0; i < 7; i++) send_event(rrp_pkg::KIND_BYTE, frame_q[i]);
    write_expect_id(1'b0);
    for (int i = 7; i < frame_q.size(); i++) send_event(rrp_pkg::KIND_BYTE, frame_q[i]);
    send_event(rrp_pkg::KIND_IDLE, 8'h00);

    write_expect_id(1'b1);
    start_items = items_sent;
    last_cfg    = items_sent;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      if (items_sent - last_cfg >= 40) begin
        write_expect_id(1'($urandom_range(0, 1)));
        last_cfg = items_sent;
      end
      gaps_on = !(items_sent - start_items >= 30 && items_sent - start_items < 80);
      r = $urandom_range(0, 99);
      if (r < 75) begin
        n = $urandom_range(0, 9);
        stat = (n < 7) ? rrp_pkg::ST_OK_CODE : (n == 7) ? rrp_pkg::ST_FAIL_CODE
                                                        : 8'($urandom);
        len = ($urandom_range(0, 29) == 0) ? 8'($urandom_range(118, 126))
                                           : 8'($urandom_range(0, 8));
        build_frame(stat, len, $urandom_range(0, 9) == 0);
        send_frame(($urandom_range(0, 11) == 0) ? $urandom_range(0, frame_q.size() - 1) : -1,
                   ($urandom_range(0, 11) == 0) ? $urandom_range(1, 4) : 0);
      end else begin
        n = $urandom_range(0, 7);
        repeat (n) send_event(1'($urandom_range(0, 1)), 8'($urandom));
        send_event(rrp_pkg::KIND_IDLE, 8'($urandom));
      end
    end
    gaps_on = 1'b1;

    drain_results();
    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/rrp_pkg.sv
sv/rrp_if.sv
sv/rrp_in_stage.sv
sv/rrp_frame_parser.sv
sv/rrp_out_stage.sv
sv/rfid_reader_response_parser.sv
verif/rrp_frame_checker.sv
verif/testbench.sv
